/* rtl/fvhsv_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and table functions of the flow to HSV color block.
package fvhsv_pkg;

    localparam int TAN_W = 30;
    localparam int TAN_STEPS = 22;
    localparam int CNT_W = 5;
    localparam logic [TAN_W-1:0] DEC_ONE = 30'd1000000000;

    // floor(x/30) for x below 7666: (x * 34953) >> 20
    localparam logic [15:0] DIV30_MUL = 16'd34953;
    localparam int DIV30_SHIFT = 20;

    localparam logic [7:0] VAL_MAX = 8'd255;
    localparam logic [7:0] HUE_QUAD = 8'd45;
    localparam logic [7:0] HUE_UPPER = 8'd22;
    localparam logic [4:0] SECTOR_SPAN = 5'd30;
    localparam logic [12:0] ROUND_HALF = 13'd15;

    typedef enum logic [2:0] {
        SEC_RED_GREEN  = 3'd0,
        SEC_GREEN_RED  = 3'd1,
        SEC_GREEN_BLUE = 3'd2,
        SEC_BLUE_GREEN = 3'd3,
        SEC_BLUE_RED   = 3'd4,
        SEC_RED_BLUE   = 3'd5
    } sector_t;

    // tan(2m degrees) scaled by 1e9
    function automatic logic [TAN_W-1:0] tan_coef(input int m);
        logic [TAN_W-1:0] c;
        unique case (m)
            1:  c = 30'd34920770;
            2:  c = 30'd69926812;
            3:  c = 30'd105104235;
            4:  c = 30'd140540835;
            5:  c = 30'd176326981;
            6:  c = 30'd212556562;
            7:  c = 30'd249328003;
            8:  c = 30'd286745386;
            9:  c = 30'd324919696;
            10: c = 30'd363970234;
            11: c = 30'd404026226;
            12: c = 30'd445228685;
            13: c = 30'd487732589;
            14: c = 30'd531709432;
            15: c = 30'd577350269;
            16: c = 30'd624869352;
            17: c = 30'd674508517;
            18: c = 30'd726542528;
            19: c = 30'd781285627;
            20: c = 30'd839099631;
            21: c = 30'd900404044;
            22: c = 30'd965688775;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] div30(input logic [12:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(DIV30_MUL);
        return p[DIV30_SHIFT+7:DIV30_SHIFT];
    endfunction

endpackage

/* rtl/fvhsv_if.sv */
`timescale 1ns / 1ps
// Stream interfaces: flow vector words in, BGR color words out.
interface flow_in_if #(parameter int FLOW_BITS = 16);
    logic                        valid;
    logic                        ready;
    logic signed [FLOW_BITS-1:0] flow_x;
    logic signed [FLOW_BITS-1:0] flow_y;
    logic                        frame_end;

    modport source (output valid, output flow_x, output flow_y, output frame_end,
                    input ready);
    modport sink   (input valid, input flow_x, input flow_y, input frame_end,
                    output ready);
endinterface

interface color_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_of_frame;

    modport source (output valid, output blue, output green, output red,
                    output last_of_frame, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input last_of_frame, output ready);
endinterface

/* rtl/fvhsv_sqrt_cell.sv */
`timescale 1ns / 1ps
// One digit of a restoring integer square root, registered.
module fvhsv_sqrt_cell #(
    parameter int W  = 48,
    parameter int NR = 24
) (
    input  logic          clk,
    input  logic [W-1:0]  n_in,
    input  logic [NR+1:0] rem_in,
    input  logic [NR-1:0] root_in,
    output logic [W-1:0]  n_out,
    output logic [NR+1:0] rem_out,
    output logic [NR-1:0] root_out
);

    logic [NR+1:0] rs;
    logic [NR+1:0] tr;
    logic          ge;

    // partial remainder stays below 2^NR, so the top two bits drop safely
    assign rs = {rem_in[NR-1:0], n_in[W-1:W-2]};
    assign tr = {root_in, 2'b01};
    assign ge = (rs >= tr);

    always_ff @(posedge clk)
    begin
        n_out    <= {n_in[W-3:0], 2'b00};
        rem_out  <= ge ? (rs - tr) : rs;
        root_out <= {root_in[NR-2:0], ge};
    end

endmodule

/* rtl/fvhsv_hue_cell.sv */
`timescale 1ns / 1ps
// One angle threshold test of the hue count, registered.
module fvhsv_hue_cell
    import fvhsv_pkg::*;
#(
    parameter int F = 16,
    parameter logic [29:0] TAN = 30'd0
) (
    input  logic               clk,
    input  logic [F-1:0]       a_in,
    input  logic [F+TAN_W-1:0] b_in,
    input  logic               lo_in,
    input  logic [CNT_W-1:0]   cnt_in,
    output logic [F-1:0]       a_out,
    output logic [F+TAN_W-1:0] b_out,
    output logic               lo_out,
    output logic [CNT_W-1:0]   cnt_out
);

    logic [F+TAN_W-1:0] prod;
    logic               hit;

    assign prod = (F+TAN_W)'(a_in) * (F+TAN_W)'(TAN);
    // below 45 deg: v*1e9 >= u*tan; above: u*1e9 <= v*tan
    assign hit  = lo_in ? (b_in >= prod) : (b_in <= prod);

    always_ff @(posedge clk)
    begin
        a_out   <= a_in;
        b_out   <= b_in;
        lo_out  <= lo_in;
        cnt_out <= cnt_in + CNT_W'(hit);
    end

endmodule

/* rtl/fvhsv_div_cell.sv */
`timescale 1ns / 1ps
// One quotient bit of the brightness division, registered.
module fvhsv_div_cell #(
    parameter int RW  = 24,
    parameter int BIT = 7
) (
    input  logic          clk,
    input  logic [RW-1:0] rem_in,
    input  logic [7:0]    q_in,
    input  logic [15:0]   divisor,
    output logic [RW-1:0] rem_out,
    output logic [7:0]    q_out
);

    localparam int CW = RW + 24;

    logic [CW-1:0] d_sh;
    logic [CW-1:0] r_ext;
    logic          ge;

    assign d_sh  = CW'(divisor) << BIT;
    assign r_ext = CW'(rem_in);
    assign ge    = (r_ext >= d_sh);

    always_ff @(posedge clk)
    begin
        rem_out <= ge ? RW'(r_ext - d_sh) : rem_in;
        q_out   <= {q_in[6:0], ge};
    end

endmodule

/* rtl/flow_vector_to_hsv_color.sv */
`timescale 1ns / 1ps
// Top level: flow vector to HSV color coding with BGR output.
// One flow word is in flight at a time; the next word is taken once its color
// word has left. Each word passes through the digit-per-cell square root chain
// over 2*FLOW_BITS+16 bits and the eight-cell brightness divider behind it;
// the 22-cell hue threshold chain runs alongside. The frame maximum used as
// divisor switches after the color word of a frame_end pixel is formed.
module flow_vector_to_hsv_color
    import fvhsv_pkg::*;
#(
    parameter int FLOW_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_data,
    flow_in_if.sink          flow,
    color_out_if.source      color
);

    localparam int F   = FLOW_BITS;
    localparam int SW  = 2 * F;
    localparam int AW  = 2 * F + 16;
    localparam int NA  = F + 8;
    localparam int PW  = F + TAN_W;
    localparam int LAT = F + 25;
    localparam int CW  = $clog2(LAT + 1);

    // control
    logic          dir_reg;
    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic [15:0]   prev_max_reg;
    logic [15:0]   run_max_reg;
    logic          in_acc;
    logic          out_acc;
    logic          out_load;

    // payload stages
    logic signed [F-1:0] x_reg, y_reg;
    logic                fend_reg;
    logic [F-1:0]        ax_reg, ay_reg, u_reg, v_reg;
    logic [1:0]          quad_reg;
    logic                zero_reg;
    logic [SW-1:0]       sqx_reg, sqy_reg, s_reg;
    logic                hlo_reg;
    logic [F-1:0]        ha_reg;
    logic [PW-1:0]       hb_reg;
    logic [SW+7:0]       t1_reg;
    logic [AW-1:0]       t2_reg;
    logic [NA-1:0]       rr_reg;
    logic                ovf_reg;

    logic [F-1:0] ax_c, ay_c;
    logic         xneg, yneg, xz, yz;
    logic [1:0]   quad_c;

    assign in_acc   = flow.valid && flow.ready;
    assign out_acc  = color.valid && color.ready;
    assign out_load = (cnt_reg == CW'(1));
    assign flow.ready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            dir_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                busy_reg <= 1'b0;
            end
            if (in_acc)
            begin
                cnt_reg <= CW'(LAT);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input word held until the next one; every later stage settles on it
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg    <= flow.flow_x;
            y_reg    <= flow.flow_y;
            fend_reg <= flow.frame_end;
        end
    end

    always_comb
    begin
        xneg = x_reg[F-1];
        yneg = y_reg[F-1];
        xz   = (x_reg == '0);
        yz   = (y_reg == '0);
        ax_c = xneg ? (~x_reg + F'(1)) : x_reg;
        ay_c = yneg ? (~y_reg + F'(1)) : y_reg;
        priority if (!xneg && !xz && !yneg)
            quad_c = 2'd0;
        else if ((xneg || xz) && !yneg && !yz)
            quad_c = 2'd1;
        else if (xneg && (yneg || yz))
            quad_c = 2'd2;
        else
            quad_c = 2'd3;
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_c;
        ay_reg   <= ay_c;
        quad_reg <= quad_c;
        zero_reg <= xz && yz;
        // odd quadrants swap the roles of the axes
        u_reg    <= quad_c[0] ? ay_c : ax_c;
        v_reg    <= quad_c[0] ? ax_c : ay_c;

        sqx_reg <= SW'(ax_reg) * SW'(ax_reg);
        sqy_reg <= SW'(ay_reg) * SW'(ay_reg);
        hlo_reg <= (v_reg < u_reg);
        ha_reg  <= (v_reg < u_reg) ? u_reg : v_reg;
        hb_reg  <= PW'((v_reg < u_reg) ? v_reg : u_reg) * PW'(DEC_ONE);

        s_reg  <= sqx_reg + sqy_reg;
        // 65025*s as two multiplies by 255
        t1_reg <= ((SW+8)'(s_reg) << 8) - (SW+8)'(s_reg);
        t2_reg <= (AW'(t1_reg) << 8) - AW'(t1_reg);
    end

    // root of 65025*s gives floor(255*|v|)
    logic [AW-1:0] an  [0:NA];
    logic [NA+1:0] arm [0:NA];
    logic [NA-1:0] art [0:NA];

    assign an[0]  = t2_reg;
    assign arm[0] = '0;
    assign art[0] = '0;

    // root of s gives the magnitude
    logic [SW-1:0] bn  [0:F];
    logic [F+1:0]  brm [0:F];
    logic [F-1:0]  brt [0:F];

    assign bn[0]  = s_reg;
    assign brm[0] = '0;
    assign brt[0] = '0;

    // hue threshold chain
    logic [F-1:0]     ca [0:TAN_STEPS];
    logic [PW-1:0]    cb [0:TAN_STEPS];
    logic             cl [0:TAN_STEPS];
    logic [CNT_W-1:0] cc [0:TAN_STEPS];

    assign ca[0] = ha_reg;
    assign cb[0] = hb_reg;
    assign cl[0] = hlo_reg;
    assign cc[0] = '0;

    // divider chain
    logic [NA-1:0] dr [0:8];
    logic [7:0]    dq [0:8];

    assign dr[0] = rr_reg;
    assign dq[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NA; gi++)
        begin : g_sqa
            fvhsv_sqrt_cell #(.W(AW), .NR(NA)) u_cell (
                .clk      (clk),
                .n_in     (an[gi]),
                .rem_in   (arm[gi]),
                .root_in  (art[gi]),
                .n_out    (an[gi+1]),
                .rem_out  (arm[gi+1]),
                .root_out (art[gi+1])
            );
        end
        for (gi = 0; gi < F; gi++)
        begin : g_sqb
            fvhsv_sqrt_cell #(.W(SW), .NR(F)) u_cell (
                .clk      (clk),
                .n_in     (bn[gi]),
                .rem_in   (brm[gi]),
                .root_in  (brt[gi]),
                .n_out    (bn[gi+1]),
                .rem_out  (brm[gi+1]),
                .root_out (brt[gi+1])
            );
        end
        for (gi = 0; gi < TAN_STEPS; gi++)
        begin : g_hue
            fvhsv_hue_cell #(.F(F), .TAN(tan_coef(gi + 1))) u_cell (
                .clk     (clk),
                .a_in    (ca[gi]),
                .b_in    (cb[gi]),
                .lo_in   (cl[gi]),
                .cnt_in  (cc[gi]),
                .a_out   (ca[gi+1]),
                .b_out   (cb[gi+1]),
                .lo_out  (cl[gi+1]),
                .cnt_out (cc[gi+1])
            );
        end
        for (gi = 0; gi < 8; gi++)
        begin : g_div
            fvhsv_div_cell #(.RW(NA), .BIT(7 - gi)) u_cell (
                .clk     (clk),
                .rem_in  (dr[gi]),
                .q_in    (dq[gi]),
                .divisor (prev_max_reg),
                .rem_out (dr[gi+1]),
                .q_out   (dq[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        rr_reg  <= art[NA];
        ovf_reg <= (48'(art[NA]) >= (48'(prev_max_reg) << 8));
    end

    // magnitude saturated to 16 bits
    logic [31:0] mag_x;
    logic [15:0] mag16;

    assign mag_x = 32'(brt[F]);
    assign mag16 = (mag_x[31:16] != '0) ? 16'hFFFF : mag_x[15:0];

    // hue, sector and brightness
    logic [7:0] hue_c, sec_c, val_c;
    logic [7:0] rem_c;
    logic [2:0] e1_sec_reg, e2_sec_reg;
    logic [4:0] e1_rem_reg;
    logic [7:0] e1_val_reg, e2_val_reg;
    logic [12:0] nt_reg, nq_reg;

    always_comb
    begin
        hue_c = zero_reg ? 8'd0
              : (HUE_QUAD * 8'(quad_reg)) + (hlo_reg ? 8'd0 : HUE_UPPER) + 8'(cc[TAN_STEPS]);
        sec_c = div30(13'(hue_c));
        rem_c = hue_c - 8'(SECTOR_SPAN) * sec_c;
        priority if (dir_reg)
            val_c = VAL_MAX;
        else if (prev_max_reg == '0 && zero_reg)
            val_c = 8'd0;
        else if (ovf_reg)
            val_c = VAL_MAX;
        else
            val_c = dq[8];
    end

    always_ff @(posedge clk)
    begin
        e1_sec_reg <= sec_c[2:0];
        e1_rem_reg <= rem_c[4:0];
        e1_val_reg <= val_c;
        e2_sec_reg <= e1_sec_reg;
        e2_val_reg <= e1_val_reg;
        nt_reg <= 13'(e1_val_reg) * 13'(e1_rem_reg) + ROUND_HALF;
        nq_reg <= 13'(e1_val_reg) * 13'(SECTOR_SPAN - e1_rem_reg) + ROUND_HALF;
    end

    logic [7:0] tv_c, qv_c;
    logic [7:0] b_c, g_c, r_c;
    logic [7:0] blue_reg, green_reg, red_reg;
    logic       last_reg;

    always_comb
    begin
        tv_c = div30(nt_reg);
        qv_c = div30(nq_reg);
        unique case (sector_t'(e2_sec_reg))
            SEC_RED_GREEN:  begin b_c = 8'd0;       g_c = tv_c;       r_c = e2_val_reg; end
            SEC_GREEN_RED:  begin b_c = 8'd0;       g_c = e2_val_reg; r_c = qv_c;       end
            SEC_GREEN_BLUE: begin b_c = tv_c;       g_c = e2_val_reg; r_c = 8'd0;       end
            SEC_BLUE_GREEN: begin b_c = e2_val_reg; g_c = qv_c;       r_c = 8'd0;       end
            SEC_BLUE_RED:   begin b_c = e2_val_reg; g_c = 8'd0;       r_c = tv_c;       end
            default:        begin b_c = qv_c;       g_c = 8'd0;       r_c = e2_val_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            blue_reg  <= b_c;
            green_reg <= g_c;
            red_reg   <= r_c;
            last_reg  <= fend_reg;
        end
    end

    // frame maximum tracking
    logic [15:0] run_max_next;

    assign run_max_next = (mag16 > run_max_reg) ? mag16 : run_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_max_reg <= '0;
            run_max_reg  <= '0;
        end
        else if (out_load)
        begin
            if (fend_reg)
            begin
                prev_max_reg <= run_max_next;
                run_max_reg  <= '0;
            end
            else
            begin
                run_max_reg <= run_max_next;
            end
        end
    end

    assign color.valid         = out_valid_reg;
    assign color.blue          = blue_reg;
    assign color.green         = green_reg;
    assign color.red           = red_reg;
    assign color.last_of_frame = last_reg;

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> busy_reg)
        else $error("color word pending while block idle");

    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (cnt_reg == CW'(LAT)))
        else $error("latency count not started on accept");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg)
        else $error("color word overwritten before taken");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && fend_reg) |=> (run_max_reg == '0))
        else $error("running maximum not cleared at frame end");

endmodule
